### hdl/jsi_pkg.sv
// Package for the joint setpoint integrator: item types, lane control types,
// register codes and the saturation helper. No dependencies.
`default_nettype none
package jsi_pkg;

  localparam int JOINTS     = 7;
  localparam int ARM_JOINTS = 6;

  localparam logic [1:0] CMD_MEASURED = 2'd0;
  localparam logic [1:0] CMD_VELOCITY = 2'd1;
  localparam logic [1:0] CMD_TICK     = 2'd2;

  localparam logic [2:0] REG_MODE   = 3'd6;
  localparam logic [2:0] REG_THRESH = 3'd7;

  localparam logic signed [31:0] ONE_Q           = 32'sd16777216;
  localparam logic [30:0]        THRESHOLD_RESET = 31'd4392264;

  typedef struct packed {
    logic [1:0]         cmd;
    logic signed [31:0] value_0;
    logic signed [31:0] value_1;
    logic signed [31:0] value_2;
    logic signed [31:0] value_3;
    logic signed [31:0] value_4;
    logic signed [31:0] value_5;
    logic signed [31:0] value_6;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] position_0;
    logic signed [31:0] position_1;
    logic signed [31:0] position_2;
    logic signed [31:0] position_3;
    logic signed [31:0] position_4;
    logic signed [31:0] position_5;
    logic signed [31:0] position_6;
    logic [5:0]         held_mask;
  } out_item_t;

  typedef struct packed {
    logic seed;
    logic meas;
    logic vel;
    logic tick;
  } lane_ctl_t;

  typedef struct packed {
    logic               clamp_on;
    logic               hold_en;
    logic               persist;
    logic signed [31:0] lo;
    logic signed [31:0] hi;
    logic [30:0]        thr;
  } lane_cfg_t;

  function automatic logic signed [31:0] sat33(input logic signed [32:0] v);
    logic signed [31:0] r;
    if (v[32] != v[31]) begin
      r = v[32] ? 32'sh8000_0000 : 32'sh7fff_ffff;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage
`default_nettype wire

### hdl/joint_setpoint_integrator_top.sv
// Seven-joint setpoint integrator with limits and threshold hold.
// A tick item gives its result in the output register in the cycle after it is taken.
// Throughput: one item per cycle; the input stalls only while a result waits under out_stall.
// Velocity items are scaled by the tick period in the lane multiplier when they are taken.
// Reset (rst_n low, synchronous) clears lane state and ready, and resets the registers.
`default_nettype none
module joint_setpoint_integrator_top #(
  parameter int TICK_PERIOD_Q = 335544
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire jsi_pkg::in_item_t   in_data,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output jsi_pkg::out_item_t       out_data,
  input  wire logic                psel,
  input  wire logic                penable,
  input  wire logic                pwrite,
  input  wire logic [5:0]          paddr,
  input  wire logic [63:0]         pwdata,
  output logic [63:0]              prdata,
  output logic                     pready
);
  import jsi_pkg::*;

  logic [5:0][63:0] limits;
  logic [7:0]       mode;
  logic [30:0]      thr;
  logic             ready_r;
  logic             accept;
  logic             do_tick;
  lane_ctl_t        ctl;
  logic [6:0][31:0] vals;
  logic [6:0][31:0] lane_pos;
  logic [6:0]       lane_held;

  jsi_regs u_regs (
    .clk, .rst_n, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .limits, .mode, .thr
  );

  assign in_stall = out_valid && out_stall;
  assign accept   = in_valid && !in_stall;
  assign do_tick  = accept && (in_data.cmd == CMD_TICK) && ready_r;

  always_comb begin
    ctl.meas = accept && (in_data.cmd == CMD_MEASURED);
    ctl.seed = ctl.meas && !ready_r;
    ctl.vel  = accept && (in_data.cmd == CMD_VELOCITY);
    ctl.tick = do_tick;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ready_r <= 1'b0;
    end else if (ctl.meas) begin
      ready_r <= 1'b1;
    end
  end

  assign vals = {in_data.value_6, in_data.value_5, in_data.value_4, in_data.value_3,
                 in_data.value_2, in_data.value_1, in_data.value_0};

  for (genvar j = 0; j < JOINTS; j++) begin : g_lane
    lane_cfg_t lcfg;
    logic signed [31:0] pos;
    if (j < ARM_JOINTS) begin : g_arm
      always_comb begin
        lcfg.clamp_on = mode[2 + j];
        lcfg.hold_en  = mode[0];
        lcfg.persist  = mode[1];
        lcfg.lo       = limits[j][31:0];
        lcfg.hi       = limits[j][63:32];
        lcfg.thr      = thr;
      end
    end else begin : g_grip
      always_comb begin
        lcfg.clamp_on = 1'b1;
        lcfg.hold_en  = 1'b0;
        lcfg.persist  = 1'b0;
        lcfg.lo       = '0;
        lcfg.hi       = ONE_Q;
        lcfg.thr      = thr;
      end
    end
    jsi_lane #(.TICK_PERIOD_Q(TICK_PERIOD_Q)) u_lane (
      .clk, .rst_n, .ctl, .lcfg,
      .value (vals[j]),
      .pos   (pos),
      .held  (lane_held[j])
    );
    assign lane_pos[j] = pos;
  end

  jsi_merge u_merge (
    .clk, .rst_n,
    .push      (do_tick),
    .lane_pos  (lane_pos),
    .lane_held (lane_held[5:0]),
    .out_stall,
    .out_valid,
    .out_data
  );

`ifndef ASSERT_OFF
  a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid) else $error("input stalled with empty output register");

  a_tick_gives_item: assert property (@(posedge clk) disable iff (!rst_n)
    do_tick |=> out_valid) else $error("accepted tick gave no result item");

  a_gripper_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.position_6 >= 0 && out_data.position_6 <= ONE_Q))
    else $error("gripper position outside 0..1");

  a_held_needs_mode: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (mode[0] || out_data.held_mask == 6'd0))
    else $error("held mask set with threshold hold off");
`endif

endmodule
`default_nettype wire

### hdl/jsi_regs.sv
// Configuration registers behind the APB-style port: joint limits, mode bits
// and the error threshold. Depends on jsi_pkg.
`default_nettype none
module jsi_regs (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             psel,
  input  wire logic             penable,
  input  wire logic             pwrite,
  input  wire logic [5:0]       paddr,
  input  wire logic [63:0]      pwdata,
  output logic [63:0]           prdata,
  output logic                  pready,
  output logic [5:0][63:0]      limits,
  output logic [7:0]            mode,
  output logic [30:0]           thr
);
  import jsi_pkg::*;

  logic [5:0][63:0] limits_r;
  logic [7:0]       mode_r;
  logic [30:0]      thr_r;
  logic [2:0]       idx;
  logic             wr;

  assign idx    = paddr[5:3];
  assign wr     = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limits_r <= '0;
      mode_r   <= '0;
      thr_r    <= THRESHOLD_RESET;
    end else if (wr) begin
      unique case (idx)
        REG_MODE:   mode_r <= pwdata[7:0];
        REG_THRESH: thr_r  <= pwdata[30:0];
        default:    limits_r[idx] <= pwdata;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_MODE:   prdata = {56'd0, mode_r};
      REG_THRESH: prdata = {33'd0, thr_r};
      default:    prdata = limits_r[idx];
    endcase
  end

  assign limits = limits_r;
  assign mode   = mode_r;
  assign thr    = thr_r;

endmodule
`default_nettype wire

### hdl/jsi_lane.sv
// One joint lane: holds setpoint, measured position and scaled velocity, and
// computes the integrate, clamp and threshold-hold step. Depends on jsi_pkg.
`default_nettype none
module jsi_lane #(
  parameter int TICK_PERIOD_Q = 335544
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire jsi_pkg::lane_ctl_t    ctl,
  input  wire jsi_pkg::lane_cfg_t    lcfg,
  input  wire logic signed [31:0]    value,
  output logic signed [31:0]         pos,
  output logic                       held
);
  import jsi_pkg::*;

  localparam logic signed [25:0] TQ = 26'(TICK_PERIOD_Q);
  localparam logic signed [57:0] HALF = 58'sd8388608;

  logic signed [31:0] setpoint_r, setpoint_nxt;
  logic signed [31:0] measured_r;
  logic signed [31:0] delta_r;
  logic signed [57:0] prod;
  logic signed [57:0] rnd;
  logic signed [31:0] sp_sum;
  logic signed [31:0] clamped;
  logic signed [32:0] err;
  logic signed [32:0] thr33;
  logic signed [32:0] up_sum;
  logic signed [32:0] dn_sum;

  assign prod = value * TQ;
  assign rnd  = prod + HALF;

  always_comb begin
    sp_sum = sat33({setpoint_r[31], setpoint_r} + {delta_r[31], delta_r});
    clamped = sp_sum;
    if (lcfg.clamp_on) begin
      if (sp_sum <= lcfg.lo) begin
        clamped = lcfg.lo;
      end else if (sp_sum >= lcfg.hi) begin
        clamped = lcfg.hi;
      end
    end
    thr33  = {2'b00, lcfg.thr};
    err    = {clamped[31], clamped} - {measured_r[31], measured_r};
    up_sum = {measured_r[31], measured_r} + thr33;
    dn_sum = {measured_r[31], measured_r} - thr33;
    pos    = clamped;
    held   = 1'b0;
    if (lcfg.hold_en) begin
      if (err > thr33) begin
        pos  = sat33(up_sum);
        held = 1'b1;
      end else if (err < -thr33) begin
        pos  = sat33(dn_sum);
        held = 1'b1;
      end
    end
    setpoint_nxt = setpoint_r;
    if (ctl.seed) begin
      setpoint_nxt = value;
    end else if (ctl.tick) begin
      setpoint_nxt = (lcfg.hold_en && lcfg.persist) ? pos : clamped;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      setpoint_r <= '0;
      measured_r <= '0;
      delta_r    <= '0;
    end else begin
      setpoint_r <= setpoint_nxt;
      if (ctl.meas) begin
        measured_r <= value;
      end
      if (ctl.vel) begin
        delta_r <= rnd[55:24];
      end
    end
  end

endmodule
`default_nettype wire

### hdl/jsi_merge.sv
// Merging stage: gathers the lane positions and hold flags into one result
// item and keeps it in the output register. Depends on jsi_pkg.
`default_nettype none
module jsi_merge (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                push,
  input  wire logic [6:0][31:0]    lane_pos,
  input  wire logic [5:0]          lane_held,
  input  wire logic                out_stall,
  output logic                     out_valid,
  output jsi_pkg::out_item_t       out_data
);
  import jsi_pkg::*;

  logic      valid_r;
  out_item_t data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (push) begin
      valid_r <= 1'b1;
    end else if (!out_stall) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      data_r.position_0 <= lane_pos[0];
      data_r.position_1 <= lane_pos[1];
      data_r.position_2 <= lane_pos[2];
      data_r.position_3 <= lane_pos[3];
      data_r.position_4 <= lane_pos[4];
      data_r.position_5 <= lane_pos[5];
      data_r.position_6 <= lane_pos[6];
      data_r.held_mask  <= lane_held;
    end
  end

  assign out_valid = valid_r;
  assign out_data  = data_r;

endmodule
`default_nettype wire
